// ===== rtl/core/pfp_pkg.sv =====
`default_nettype none
package pfp_pkg;

   // input coordinate format
   localparam int CW = 32;
   localparam int FB = 16;
   // fraction bits of the unit normal
   localparam int NF = 30;
   // edge vector, cross product and square widths
   localparam int DW   = 33;
   localparam int PW   = 66;
   localparam int CMW  = 65;
   localparam int SQW  = 130;
   localparam int SW   = 132;
   // quotient, running q*S and residual widths
   localparam int QW   = NF + 1;
   localparam int YW   = SW + QW;
   localparam int RW   = 196;
   localparam int OW   = 48;
   localparam int TW   = 32;

   typedef logic signed [CW-1:0] coord_type;

   // item moving along the chain of cells
   typedef struct packed {
      logic                     valid;
      logic                     degen;
      logic [2:0]               neg;
      logic [2:0][CW-1:0]       a;
      logic [SW-1:0]            s;
      logic [2:0][RW-1:0]       r;
      logic [2:0][YW-1:0]       y;
      logic [2:0][QW-1:0]       q;
   } cell_type;

endpackage
`default_nettype wire

// ===== rtl/core/pfp_front.sv =====
`default_nettype none
module pfp_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      en,
   input  wire                      in_valid,
   input  wire [8:0][pfp_pkg::CW-1:0] pts,
   input  wire [pfp_pkg::TW-1:0]    thr,
   output pfp_pkg::cell_type        out
);
   import pfp_pkg::*;

   logic                  a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic                  f_valid_ff;
   logic [2:0][CW-1:0]    pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [DW-1:0]  d1_ff [3];
   logic signed [DW-1:0]  d2_ff [3];
   logic signed [PW-1:0]  u_ff [3];
   logic signed [PW-1:0]  v_ff [3];
   logic [CMW-1:0]        cmag_ff [3];
   logic [2:0]            cneg_ff, dneg_ff, eneg_ff, fneg_ff;
   logic [65:0]           hh_ff [3];
   logic [64:0]           hl_ff [3];
   logic [63:0]           ll_ff [3];
   logic [2*TW-1:0]       thr2_d_ff, thr2_e_ff, thr2_f_ff;
   logic [SQW-1:0]        sq_e_ff [3];
   logic [SQW-1:0]        sq_f_ff [3];
   logic [SW-1:0]         s_ff;
   cell_type              out_ff;

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         out_ff.valid <= f_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         // edge vectors
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= pts[i];
            d1_ff[i] <= $signed({pts[3+i][CW-1], pts[3+i]}) - $signed({pts[i][CW-1], pts[i]});
            d2_ff[i] <= $signed({pts[6+i][CW-1], pts[6+i]}) - $signed({pts[i][CW-1], pts[i]});
         end
         // cross product terms
         pb_ff <= pa_ff;
         u_ff[0] <= d1_ff[1] * d2_ff[2];
         v_ff[0] <= d1_ff[2] * d2_ff[1];
         u_ff[1] <= d1_ff[2] * d2_ff[0];
         v_ff[1] <= d1_ff[0] * d2_ff[2];
         u_ff[2] <= d1_ff[0] * d2_ff[1];
         v_ff[2] <= d1_ff[1] * d2_ff[0];
         // cross components as magnitude and sign
         pc_ff <= pb_ff;
         for (int i = 0; i < 3; i++) begin
            logic signed [PW:0] df;
            df = $signed({u_ff[i][PW-1], u_ff[i]}) - $signed({v_ff[i][PW-1], v_ff[i]});
            cneg_ff[i] <= df[PW];
            cmag_ff[i] <= df[PW] ? CMW'(-df) : CMW'(df);
         end
         // partial squares
         pd_ff <= pc_ff;
         dneg_ff <= cneg_ff;
         thr2_d_ff <= (2*TW)'(thr) * (2*TW)'(thr);
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= 66'(cmag_ff[i][CMW-1:32]) * 66'(cmag_ff[i][CMW-1:32]);
            hl_ff[i] <= 65'(cmag_ff[i][CMW-1:32]) * 65'(cmag_ff[i][31:0]);
            ll_ff[i] <= 64'(cmag_ff[i][31:0]) * 64'(cmag_ff[i][31:0]);
         end
         // squares
         pe_ff <= pd_ff;
         eneg_ff <= dneg_ff;
         thr2_e_ff <= thr2_d_ff;
         for (int i = 0; i < 3; i++) begin
            sq_e_ff[i] <= {hh_ff[i], 64'd0} + (SQW'(hl_ff[i]) << 33) + SQW'(ll_ff[i]);
         end
         // sum of squares
         pf_ff <= pe_ff;
         fneg_ff <= eneg_ff;
         thr2_f_ff <= thr2_e_ff;
         sq_f_ff <= sq_e_ff;
         s_ff <= SW'(sq_e_ff[0]) + SW'(sq_e_ff[1]) + SW'(sq_e_ff[2]);
         // length test and chain seed
         out_ff.degen <= (s_ff == '0) || (s_ff < SW'(thr2_f_ff));
         out_ff.neg <= fneg_ff;
         out_ff.a <= pf_ff;
         out_ff.s <= s_ff;
         for (int i = 0; i < 3; i++) begin
            out_ff.r[i] <= RW'({sq_f_ff[i], {(2*NF){1'b0}}});
            out_ff.y[i] <= '0;
            out_ff.q[i] <= '0;
         end
      end
   end

   assign out = out_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pfp_cell.sv =====
`default_nettype none
module pfp_cell #(
   parameter int BIT = 0
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                en,
   input  pfp_pkg::cell_type  din,
   output pfp_pkg::cell_type  dout
);
   import pfp_pkg::*;

   cell_type dout_ff;
   cell_type dout_in;

   // one quotient bit of |c|*2^NF/sqrt(S) for each component
   always_comb begin
      logic [RW-1:0] inc;
      logic          take;
      dout_in = din;
      for (int i = 0; i < 3; i++) begin
         inc  = (RW'(din.y[i]) << (BIT + 1)) + (RW'(din.s) << (2 * BIT));
         take = (inc <= din.r[i]);
         if (take) begin
            dout_in.r[i] = din.r[i] - inc;
            dout_in.y[i] = din.y[i] + (YW'(din.s) << BIT);
            dout_in.q[i] = din.q[i] | (QW'(1) << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff.valid <= 1'b0;
      end else if (en) begin
         dout_ff.valid <= dout_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dout_ff.degen <= dout_in.degen;
         dout_ff.neg   <= dout_in.neg;
         dout_ff.a     <= dout_in.a;
         dout_ff.s     <= dout_in.s;
         dout_ff.r     <= dout_in.r;
         dout_ff.y     <= dout_in.y;
         dout_ff.q     <= dout_in.q;
      end
   end

   assign dout = dout_ff;

endmodule
`default_nettype wire

// ===== rtl/core/plane_from_three_points_unit.sv =====
// Plane through three points.
// Input channel req_: one transfer carries the three points a, b, c as nine
// signed Q16.16 coordinates. Result channel rsp_: one transfer per input
// carries the unit normal (Q2.30) and the offset d = -dot(a, n) (Q32.16),
// with the determined flag on rsp_tuser. A degenerate triple gives a zero
// normal, offset 1.0 and determined low.
// csr_write_enable/csr_write_data set the near-zero threshold (reset 1);
// write it only while no item is in flight.
// Throughput: one item per cycle unless the receiver stalls. Input transfers
// reach rsp_tvalid through the 7 front stages, the 31 cells of the normal
// division chain (one quotient bit each), 2 offset stages and the output
// register.
// Reset clears all valid flags and the threshold goes to 1.
// When the receiver stalls, one more result is caught in a skid register;
// after that req_tready drops and the whole pipeline holds.
`default_nettype none
module plane_from_three_points_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // ax, ay, az, bx, by, bz, cx, cy, cz (32 bits each)
   input  wire [287:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // nx, ny, nz (32 bits each), offset (48 bits)
   output logic [143:0] rsp_tdata,
   // determined
   output logic         rsp_tuser,
   input  wire          csr_write_enable,
   input  wire [31:0]   csr_write_data
);
   import pfp_pkg::*;

   logic [TW-1:0]      thr_ff;
   logic               en;
   logic [8:0][CW-1:0] pts;
   cell_type           chain [QW+1];

   logic               h_valid_ff, h_degen_ff, i_valid_ff, i_degen_ff;
   logic signed [CW-1:0] h_n_ff [3];
   logic signed [CW-1:0] i_n_ff [3];
   logic signed [63:0] h_prod_ff [3];
   logic signed [65:0] i_acc_ff;

   logic               rsp_valid_ff, skid_valid_ff;
   logic [143:0]       rsp_data_ff, skid_data_ff, res_data;
   logic               rsp_user_ff, skid_user_ff, res_user;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= TW'(1);
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         pts[i] = req_tdata[i*CW +: CW];
      end
   end

   pfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .pts      (pts),
      .thr      (thr_ff),
      .out      (chain[0])
   );

   // division chain, most significant quotient bit first
   for (genvar k = 0; k < QW; k++) begin : g_cell
      pfp_cell #(.BIT(NF - k)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .din   (chain[k]),
         .dout  (chain[k+1])
      );
   end

   // offset: products, then sum
   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
      end else if (en) begin
         h_valid_ff <= chain[QW].valid;
         i_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         logic signed [CW-1:0] n;
         h_degen_ff <= chain[QW].degen;
         for (int i = 0; i < 3; i++) begin
            n = chain[QW].neg[i] ? -$signed(CW'(chain[QW].q[i])) : $signed(CW'(chain[QW].q[i]));
            h_n_ff[i]    <= n;
            h_prod_ff[i] <= $signed(chain[QW].a[i]) * n;
         end
         i_degen_ff <= h_degen_ff;
         i_n_ff     <= h_n_ff;
         i_acc_ff   <= 66'(h_prod_ff[0]) + 66'(h_prod_ff[1]) + 66'(h_prod_ff[2]);
      end
   end

   // rounding and degenerate select
   always_comb begin
      logic [64:0]   amag;
      logic [35:0]   rmag;
      logic [OW-1:0] off;
      amag = i_acc_ff[65] ? 65'(-i_acc_ff) : 65'(i_acc_ff);
      rmag = 36'((66'(amag) + (66'(1) << (NF - 1))) >> NF);
      off  = (!i_acc_ff[65] && (i_acc_ff != '0)) ? -OW'(rmag) : OW'(rmag);
      if (i_degen_ff) begin
         res_data = {OW'(1) << FB, 96'd0};
         res_user = 1'b0;
      end else begin
         res_data = {off, i_n_ff[2], i_n_ff[1], i_n_ff[0]};
         res_user = 1'b1;
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= i_valid_ff;
         end
      end else if (en && i_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
            rsp_user_ff <= skid_user_ff;
         end else begin
            rsp_data_ff <= res_data;
            rsp_user_ff <= res_user;
         end
      end else if (en) begin
         skid_data_ff <= res_data;
         skid_user_ff <= res_user;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
   import pfp_pkg::*;

   // one result transfer, split into its fields
   typedef struct {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [47:0] offset;
      logic               determined;
   } plane_type;

   // tracks expected planes and compares them against the result stream
   class plane_scoreboard;
      plane_type   planes_due[$];
      logic [31:0] threshold;
      int          errors;

      function new();
         threshold = 32'd1;
         errors    = 0;
      endfunction

      task report(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      // exact plane through the three points under the current threshold
      function plane_type fit_plane(input logic [287:0] pts);
         logic signed [127:0] p [9];
         logic signed [127:0] e1 [3];
         logic signed [127:0] e2 [3];
         logic signed [127:0] cr [3];
         logic signed [127:0] nn [3];
         logic [255:0]        cm [3];
         logic [255:0]        sum_sq;
         logic [255:0]        thr_sq;
         logic [255:0]        goal;
         logic [255:0]        trial;
         logic [255:0]        quo;
         logic signed [127:0] acc;
         logic [127:0]        mag;
         logic signed [127:0] d;
         plane_type           res;
         for (int i = 0; i < 9; i++) p[i] = $signed(pts[32*i +: 32]);
         for (int i = 0; i < 3; i++) begin
            e1[i] = p[3+i] - p[i];
            e2[i] = p[6+i] - p[i];
         end
         cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
         cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
         cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
         sum_sq = '0;
         for (int i = 0; i < 3; i++) begin
            cm[i] = cr[i] < 0 ? 256'(-cr[i]) : 256'(cr[i]);
            sum_sq = sum_sq + cm[i]*cm[i];
         end
         thr_sq = 256'(threshold) * 256'(threshold);
         // degenerate: no normal, offset of one
         if (sum_sq == 0 || sum_sq < thr_sq) begin
            res.nx = '0;
            res.ny = '0;
            res.nz = '0;
            res.offset = 48'sd1 <<< FB;
            res.determined = 1'b0;
            return res;
         end
         // normal components, truncated toward zero, one bit at a time
         for (int i = 0; i < 3; i++) begin
            goal = (cm[i]*cm[i]) << (2*NF);
            quo = '0;
            for (int b = NF; b >= 0; b--) begin
               trial = quo | (256'd1 << b);
               if (trial*trial*sum_sq <= goal) quo = trial;
            end
            nn[i] = cr[i] < 0 ? -$signed(128'(quo)) : $signed(128'(quo));
         end
         // offset is minus the dot product, rounded half away from zero
         acc = '0;
         for (int i = 0; i < 3; i++) acc = acc + p[i]*nn[i];
         mag = acc < 0 ? 128'(-acc) : 128'(acc);
         mag = (mag + (128'd1 << (NF-1))) >> NF;
         d = acc > 0 ? -$signed(mag) : $signed(mag);
         if (d > 128'sh7FFF_FFFF_FFFF) d = 128'sh7FFF_FFFF_FFFF;
         if (d < -128'sh8000_0000_0000) d = -128'sh8000_0000_0000;
         res.nx = nn[0][31:0];
         res.ny = nn[1][31:0];
         res.nz = nn[2][31:0];
         res.offset = d[47:0];
         res.determined = 1'b1;
         return res;
      endfunction

      function void note_request(input logic [287:0] pts);
         planes_due.push_back(fit_plane(pts));
      endfunction

      task check_response(input logic [143:0] data, input logic det);
         plane_type want;
         if (planes_due.size() == 0) begin
            report("result transfer with nothing expected");
            return;
         end
         want = planes_due.pop_front();
         if (data[31:0] !== want.nx)
            report($sformatf("nx got %h want %h", data[31:0], want.nx));
         if (data[63:32] !== want.ny)
            report($sformatf("ny got %h want %h", data[63:32], want.ny));
         if (data[95:64] !== want.nz)
            report($sformatf("nz got %h want %h", data[95:64], want.nz));
         if (data[143:96] !== want.offset)
            report($sformatf("offset got %h want %h", data[143:96], want.offset));
         if (det !== want.determined)
            report($sformatf("determined got %b want %b", det, want.determined));
      endtask
   endclass

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [287:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [143:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          csr_write_enable;
   logic [31:0]   csr_write_data;

   plane_scoreboard planes = new();
   int  hold_cycles = 0;
   bit  calm = 0;

   plane_from_three_points_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #20000000;
      $display("Test completed with failures");
      $finish;
   end

   // monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) planes.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) planes.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // receiver: random stall bursts and requested long hold-offs
   initial begin
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            stall = $urandom_range(0, 11);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [287:0] pack_points(input logic [31:0] c [9]);
      logic [287:0] v;
      for (int i = 0; i < 9; i++) v[32*i +: 32] = c[i];
      return v;
   endfunction

   // one input transfer, with an optional idle burst in front
   task automatic send_points(input logic [287:0] pts, input bit may_idle);
      if (may_idle && !calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pts;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (planes.planes_due.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [31:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      planes.threshold = value;
   endtask

   // random triple of a given flavour
   function automatic logic [287:0] random_points(input int flavour);
      logic [31:0]        c [9];
      logic signed [31:0] dir [3];
      int                 k;
      for (int i = 0; i < 9; i++) begin
         case (flavour)
            0:       c[i] = $urandom;
            1:       c[i] = 32'($signed($urandom_range(0, 128)) - 64);
            default: c[i] = 32'($signed($urandom_range(0, 2097152)) - 1048576);
         endcase
      end
      // points along one line, occasionally nudged off it
      if (flavour == 3) begin
         k = $signed($urandom_range(0, 6)) - 3;
         for (int i = 0; i < 3; i++) begin
            dir[i] = $signed($urandom_range(0, 2000)) - 1000;
            c[3+i] = c[i] + dir[i];
            c[6+i] = c[i] + k*dir[i];
         end
         if ($urandom_range(0, 2) == 0) c[6 + $urandom_range(0, 2)] += 1;
      end
      return pack_points(c);
   endfunction

   task automatic random_phase(input int count);
      for (int n = 0; n < count; n++)
         send_points(random_points($urandom_range(0, 3)), 1'b1);
   endtask

   task automatic directed_set;
      localparam logic [31:0] ONE = 32'h0001_0000;
      localparam logic [31:0] MX  = 32'h7FFF_FFFF;
      localparam logic [31:0] MN  = 32'h8000_0000;
      logic [31:0] c [9];
      // all three points coincide
      c = '{default: 32'd0};
      send_points(pack_points(c), 1'b0);
      // unit triangle in the xy plane
      c = '{32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0};
      send_points(pack_points(c), 1'b0);
      // same triangle lifted to z = 5, offset nonzero
      c = '{32'd0, 32'd0, 5*ONE, ONE, 32'd0, 5*ONE, 32'd0, ONE, 5*ONE};
      send_points(pack_points(c), 1'b0);
      // collinear points
      c = '{ONE, ONE, ONE, 2*ONE, 3*ONE, 4*ONE, 3*ONE, 5*ONE, 7*ONE};
      send_points(pack_points(c), 1'b0);
      // smallest nonzero cross product
      c = '{32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0};
      send_points(pack_points(c), 1'b0);
      // coordinate extremes
      c = '{MN, MN, MN, MX, MX, MX, MN, MX, MN};
      send_points(pack_points(c), 1'b0);
      c = '{MX, MX, MX, MN, MN, MN, MX, MN, MN};
      send_points(pack_points(c), 1'b0);
      c = '{MX, MN, MX, MN, MX, MN, MN, MN, MX};
      send_points(pack_points(c), 1'b0);
      c = '{MN, MX, 32'd0, MX, MN, MX, MX, MX, MN};
      send_points(pack_points(c), 1'b0);
      c = '{MX, MX, MX, MX, MX, MX, MX, MX, MX};
      send_points(pack_points(c), 1'b0);
      // negative normal direction and mixed signs
      c = '{-ONE, 2*ONE, -3*ONE, 4*ONE, -ONE, ONE, -2*ONE, -5*ONE, 6*ONE};
      send_points(pack_points(c), 1'b0);
      c = '{32'd7, -32'd3, 32'd11, -32'd5, 32'd9, -32'd2, 32'd1, 32'd4, -32'd8};
      send_points(pack_points(c), 1'b0);
   endtask

   // stimulus
   initial begin
      reset            <= 1'b1;
      req_tvalid       <= 1'b0;
      req_tdata        <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset threshold of one
      directed_set();
      random_phase(80);

      // zero threshold: only a vanishing cross product is degenerate
      write_threshold(32'd0);
      directed_set();
      random_phase(60);

      // receiver holds off while the sender keeps offering
      write_threshold(32'hFFFF_FFFF);
      hold_cycles = 300;
      for (int n = 0; n < 120; n++) send_points(random_points($urandom_range(0, 3)), 1'b0);
      random_phase(40);
      // sender waits for every result before going on
      drain();
      directed_set();
      random_phase(60);

      write_threshold(32'd2);
      send_points(random_points(1), 1'b0);
      random_phase(80);

      write_threshold($urandom_range(1, 4096));
      random_phase(60);

      write_threshold($urandom);
      random_phase(40);

      // closing stretch without idling
      calm = 1;
      random_phase(80);

      drain();
      repeat (60) @(posedge clock);
      while (planes.planes_due.size() > 0) begin
         void'(planes.planes_due.pop_front());
         planes.report("expected result never arrived");
      end
      if (planes.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire

// ===== plane_from_three_points_unit.f =====
rtl/core/pfp_pkg.sv
rtl/core/pfp_front.sv
rtl/core/pfp_cell.sv
rtl/core/plane_from_three_points_unit.sv
dv/tb.sv
